@@ hdl/tdpt_pkg.sv @@
// ============================================================================
// tdpt_pkg
// Shared constants and controller/datapath handshake types for the
// trial-division prime test unit.
// ============================================================================
package tdpt_pkg;

  // default candidate width
  localparam int unsigned DEF_NUMBER_WIDTH = 16;

  // first divisor tried and its square
  localparam int unsigned FIRST_DIVISOR    = 2;
  localparam int unsigned FIRST_DIV_SQUARE = FIRST_DIVISOR * FIRST_DIVISOR;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture candidate, reset divisor and square
    logic rem_start;  // start remainder of candidate by divisor
    logic step;       // advance to next divisor
    logic post;       // write result into output register
    logic verdict;    // prime flag written on post
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic small_num;  // candidate below two
    logic square_gt;  // divisor squared exceeds candidate
    logic rem_done;   // remainder finished this cycle
    logic rem_zero;   // finished remainder is zero
  } status_t;

endpackage

@@ hdl/tdpt_rem.sv @@
// ============================================================================
// tdpt_rem
// Iterative restoring remainder unit: one quotient bit per cycle.
// ============================================================================
module tdpt_rem #(
  parameter int unsigned NUMBER_WIDTH = tdpt_pkg::DEF_NUMBER_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [NUMBER_WIDTH-1:0] dividend,
  input  logic [NUMBER_WIDTH-1:0] divisor,
  output logic                    done,
  output logic                    rem_zero
);

  localparam int unsigned CNT_W = (NUMBER_WIDTH > 1) ? $clog2(NUMBER_WIDTH) : 1;

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [NUMBER_WIDTH-1:0] rem_r, rem_nxt;
  logic [NUMBER_WIDTH-1:0] shift_r, shift_nxt;
  logic [NUMBER_WIDTH:0]   trial;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    shift_nxt = shift_r;
    trial     = {rem_r, shift_r[NUMBER_WIDTH-1]};
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      rem_nxt   = '0;
      shift_nxt = dividend;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = NUMBER_WIDTH'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[NUMBER_WIDTH-1:0];
      end
      shift_nxt = {shift_r[NUMBER_WIDTH-2:0], 1'b0};
      cnt_nxt   = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(NUMBER_WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    shift_r <= shift_nxt;
  end

  assign done     = done_r;
  assign rem_zero = (rem_r == '0);

endmodule

@@ hdl/tdpt_datapath.sv @@
// ============================================================================
// tdpt_datapath
// Candidate, divisor and divisor-square registers, remainder unit and the
// result register.
// ============================================================================
module tdpt_datapath #(
  parameter int unsigned NUMBER_WIDTH = tdpt_pkg::DEF_NUMBER_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tdpt_pkg::cmd_t          cmd,
  output tdpt_pkg::status_t       status,
  input  logic [NUMBER_WIDTH-1:0] candidate,
  output logic                    prime_flag,
  output logic [NUMBER_WIDTH-1:0] tested_value
);

  // square of divisor may exceed the candidate range by a little
  localparam int unsigned SQ_W = NUMBER_WIDTH + 2;

  logic [NUMBER_WIDTH-1:0] num_r;
  logic [NUMBER_WIDTH-1:0] div_r;
  logic [SQ_W-1:0]         sq_r;
  logic                    prime_r;
  logic [NUMBER_WIDTH-1:0] tested_r;
  logic                    rem_done;
  logic                    rem_zero;

  // candidate, divisor and running square: (d+1)^2 = d^2 + 2d + 1
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r <= candidate;
      div_r <= NUMBER_WIDTH'(tdpt_pkg::FIRST_DIVISOR);
      sq_r  <= SQ_W'(tdpt_pkg::FIRST_DIV_SQUARE);
    end else if (cmd.step) begin
      div_r <= div_r + NUMBER_WIDTH'(1);
      sq_r  <= sq_r + SQ_W'({div_r, 1'b1});
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.post) begin
      prime_r  <= cmd.verdict;
      tested_r <= num_r;
    end
  end

  tdpt_rem #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.rem_start),
    .dividend (num_r),
    .divisor  (div_r),
    .done     (rem_done),
    .rem_zero (rem_zero)
  );

  // status back to controller
  always_comb begin
    status.small_num = (num_r[NUMBER_WIDTH-1:1] == '0);
    status.square_gt = (sq_r > SQ_W'(num_r));
    status.rem_done  = rem_done;
    status.rem_zero  = rem_zero;
  end

  assign prime_flag   = prime_r;
  assign tested_value = tested_r;

endmodule

@@ hdl/tdpt_ctrl.sv @@
// ============================================================================
// tdpt_ctrl
// Sequencer for the prime test: accept, check bound, divide, post result.
// Owns the input ready and the output valid.
// ============================================================================
module tdpt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output tdpt_pkg::cmd_t    cmd,
  input  tdpt_pkg::status_t status
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_POST   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   verdict_r, verdict_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   slot_free;

  assign slot_free = !ovalid_r || out_tready;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    verdict_nxt = verdict_r;
    cmd         = '0;
    cmd.verdict = verdict_r;
    in_tready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.small_num) begin
          verdict_nxt = 1'b0;
          state_nxt   = ST_POST;
        end else if (status.square_gt) begin
          verdict_nxt = 1'b1;
          state_nxt   = ST_POST;
        end else begin
          cmd.rem_start = 1'b1;
          state_nxt     = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status.rem_done) begin
          if (status.rem_zero) begin
            verdict_nxt = 1'b0;
            state_nxt   = ST_POST;
          end else begin
            cmd.step  = 1'b1;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_POST: begin
        if (slot_free) begin
          cmd.post  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid: set on post, cleared when taken
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.post) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      verdict_r <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      verdict_r <= verdict_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  assign out_tvalid = ovalid_r;

endmodule

@@ hdl/trial_division_prime_test_unit.sv @@
// ============================================================================
// trial_division_prime_test_unit
// Trial-division primality test of one unsigned candidate per input beat.
// ============================================================================
// Usage:
//   Input channel in_*: one candidate per beat in in_tdata. Output channel
//   out_*: one result beat per candidate, carrying the prime flag and the
//   candidate it refers to.
//   Divisors are tried from two upward until a divisor divides the candidate
//   or its square exceeds the candidate. Each divisor takes one bound check
//   and a pass through the bit-serial remainder unit (its done flag is
//   registered); at most about sqrt(2^NUMBER_WIDTH) divisors are tried.
//   Candidates below two skip the remainder unit and go straight to post.
//   One candidate is in work at a time; in_tready is high only while idle.
//   The result sits in an output register, so the next candidate is taken
//   while an earlier result still waits for out_tready. If the receiver
//   stalls for longer, the finished test holds until the register frees.
//   Reset (rst_n low, synchronous) returns to idle and drops out_tvalid.
// ============================================================================
module trial_division_prime_test_unit #(
  parameter int unsigned NUMBER_WIDTH = tdpt_pkg::DEF_NUMBER_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // candidate
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]     in_tdata,
  // prime_flag, tested_value
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((NUMBER_WIDTH+8)/8)*8-1:0]     out_tdata
);

  localparam int unsigned OUT_TDATA_W = ((NUMBER_WIDTH + 8) / 8) * 8;

  tdpt_pkg::cmd_t          cmd;
  tdpt_pkg::status_t       status;
  logic                    prime_flag;
  logic [NUMBER_WIDTH-1:0] tested_value;

  tdpt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  tdpt_datapath #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .candidate    (in_tdata[NUMBER_WIDTH-1:0]),
    .prime_flag   (prime_flag),
    .tested_value (tested_value)
  );

  // pack result, zero padded
  assign out_tdata = OUT_TDATA_W'({tested_value, prime_flag});

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // a result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post |-> (!out_tvalid || out_tready))
    else $error("result register overwritten");

  // candidate is captured only on an accepted beat
  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (in_tvalid && in_tready))
    else $error("load without accepted beat");

  // no new candidate while a remainder completes
  a_busy_divide: assert property (@(posedge clk) disable iff (!rst_n)
    status.rem_done |-> !in_tready)
    else $error("input ready during division");

  // after an accepted beat the unit is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready right after accept");

endmodule
